// File: rtl/core/fdt_pkg.sv
package fdt_pkg;

   // Time fields on the ports are fixed at 32 bits; TIME_WIDTH only bounds
   // the usable counter width.
   localparam int TIME_WIDTH     = 32;
   localparam int MAX_BITS_RAW   = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
   localparam int MAX_BITS       = (MAX_BITS_RAW < 16) ? 16 : MAX_BITS_RAW;
   localparam int MIN_BITS       = 16;

   localparam int PERIOD_WIDTH   = 31;
   localparam int BITS_WIDTH     = 6;
   localparam int CSR_DATA_WIDTH = 31;
   localparam int CSR_IDX_WIDTH  = 1;

   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(1000);
   localparam logic [BITS_WIDTH-1:0]   BITS_RESET   = BITS_WIDTH'(32);

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PERIOD       = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COUNTER_BITS = 1'b1;

   // Request kinds
   localparam logic REQ_POLL        = 1'b0;
   localparam logic REQ_RESET_STATS = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] now_us;
   } fdt_req_type;

   typedef struct packed {
      logic        fired;
      logic        overran;
      logic [31:0] dt_us;
      logic [31:0] iteration_count;
      logic [31:0] overrun_count;
      logic [31:0] peak_late;
   } fdt_rsp_type;

   typedef struct packed {
      logic        armed;
      logic [31:0] due_time;
      logic [31:0] prev_release;
      logic [31:0] last_dt;
      logic [31:0] iterations;
      logic [31:0] overruns;
      logic [31:0] worst_late;
   } fdt_state_type;

endpackage

// File: rtl/core/fixed_rate_deadline_tracker.sv
// Channel        | Ports                                   | Direction
// ---------------+-----------------------------------------+----------
// request        | req_valid, req_ready, req_payload       | in
// response       | rsp_valid, rsp_ready, rsp_payload       | out
// configuration  | csr_we, csr_index, csr_wdata            | in
//
// One request is taken per cycle while the response side is not stalled;
// it passes through the input register, then the response register, which
// presents its response. The tracker state is
// updated by the step logic as a request moves from the input register into
// the response register, so consecutive requests chain without gaps.
// A stalled response holds both stages; reset is synchronous and active high.
module fixed_rate_deadline_tracker import fdt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  fdt_req_type               req_payload,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output fdt_rsp_type               rsp_payload,

   input  logic                      csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   // Configuration registers
   logic [PERIOD_WIDTH-1:0] period_ff;
   logic [BITS_WIDTH-1:0]   bits_ff;

   // Input stage
   logic                    in_valid_ff;
   fdt_req_type             in_req_ff;

   // Tracker state
   fdt_state_type           state_ff;
   fdt_state_type           state_in;

   // Response stage
   logic                    out_valid_ff;
   fdt_rsp_type             out_rsp_ff;
   fdt_rsp_type             out_rsp_in;

   logic                    advance;

   // Move the held request on whenever the response register is free or
   // is being drained this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         bits_ff   <= BITS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PERIOD:       period_ff <= csr_wdata[PERIOD_WIDTH-1:0];
            CSR_COUNTER_BITS: bits_ff   <= csr_wdata[BITS_WIDTH-1:0];
            default:          ;
         endcase
      end
   end

   // Capture a request; hold it while the response side stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= req_payload;
      end
   end

   fdt_step u_step (
      .period_cfg   (period_ff),
      .counter_bits (bits_ff),
      .req          (in_req_ff),
      .state_cur    (state_ff),
      .state_nxt    (state_in),
      .rsp          (out_rsp_in)
   );

   // Commit the new state only when the request actually advances
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.armed        <= 1'b0;
         state_ff.due_time     <= 32'd0;
         state_ff.prev_release <= 32'd0;
         state_ff.last_dt      <= 32'(PERIOD_RESET);
         state_ff.iterations   <= 32'd0;
         state_ff.overruns     <= 32'd0;
         state_ff.worst_late   <= 32'd0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Response register: drop valid once taken, reload on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

endmodule

// File: rtl/core/fdt_step.sv
module fdt_step import fdt_pkg::*; (
   input  logic [PERIOD_WIDTH-1:0] period_cfg,
   input  logic [BITS_WIDTH-1:0]   counter_bits,
   input  fdt_req_type             req,
   input  fdt_state_type           state_cur,
   output fdt_state_type           state_nxt,
   output fdt_rsp_type             rsp
);

   logic [BITS_WIDTH-1:0] eff_bits;
   logic [32:0]           one_shifted;
   logic [31:0]           mask;
   logic [31:0]           half;
   logic [31:0]           period;
   logic [31:0]           now;
   logic [31:0]           late;
   logic                  fired;
   logic                  overran;

   // Clamp the counter width and build the time mask
   always_comb begin
      if (counter_bits < BITS_WIDTH'(MIN_BITS)) begin
         eff_bits = BITS_WIDTH'(MIN_BITS);
      end else if (counter_bits > BITS_WIDTH'(MAX_BITS)) begin
         eff_bits = BITS_WIDTH'(MAX_BITS);
      end else begin
         eff_bits = counter_bits;
      end
      one_shifted = 33'd1 << eff_bits;
      mask        = 32'(one_shifted - 33'd1);
      half        = mask >> 1;
   end

   // Effective period: at least one, at most half the range
   always_comb begin
      period = {1'b0, period_cfg};
      if (period == 32'd0) begin
         period = 32'd1;
      end
      if (period > half) begin
         period = half;
      end
   end

   assign now  = req.now_us & mask;
   assign late = (now - state_cur.due_time) & mask;

   always_comb begin
      state_nxt = state_cur;
      fired     = 1'b0;
      overran   = 1'b0;
      if (req.req_type == REQ_RESET_STATS) begin
         state_nxt.iterations = 32'd0;
         state_nxt.overruns   = 32'd0;
         state_nxt.worst_late = 32'd0;
      end else if (!state_cur.armed) begin
         fired                  = 1'b1;
         state_nxt.armed        = 1'b1;
         state_nxt.prev_release = now;
         state_nxt.due_time     = (now + period) & mask;
         state_nxt.last_dt      = period;
         state_nxt.iterations   = 32'd1;
      end else if (late <= half) begin
         fired                  = 1'b1;
         state_nxt.last_dt      = (now - state_cur.prev_release) & mask;
         state_nxt.prev_release = now;
         state_nxt.iterations   = state_cur.iterations + 32'd1;
         if (late > state_cur.worst_late) begin
            state_nxt.worst_late = late;
         end
         if (late >= period) begin
            overran            = 1'b1;
            state_nxt.overruns = state_cur.overruns + 32'd1;
            state_nxt.due_time = (now + period) & mask;
         end else begin
            state_nxt.due_time = (state_cur.due_time + period) & mask;
         end
      end
   end

   always_comb begin
      rsp.fired           = fired;
      rsp.overran         = overran;
      rsp.dt_us           = state_nxt.last_dt;
      rsp.iteration_count = state_nxt.iterations;
      rsp.overrun_count   = state_nxt.overruns;
      rsp.peak_late       = state_nxt.worst_late;
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import fdt_pkg::*;

   // Cycles of no progress on either channel before the run is abandoned
   localparam int STALL_LIMIT   = 4000;
   // Margin after the last response, as the response register follows the input register
   localparam int PIPE_SETTLE   = 4;
   localparam int SEGMENTS      = 6;
   localparam int SEGMENT_ITEMS = 275;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   fdt_req_type req_payload = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   fdt_rsp_type rsp_payload;

   logic                      csr_we    = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = CSR_PERIOD;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // Register copies as last written
   logic [PERIOD_WIDTH-1:0] cfg_period = PERIOD_RESET;
   logic [BITS_WIDTH-1:0]   cfg_bits   = BITS_RESET;

   // Tracker state as the block should hold it
   logic        trk_armed        = 1'b0;
   logic [31:0] trk_deadline     = '0;
   logic [31:0] trk_prev_release = '0;
   logic [31:0] trk_last_dt      = 32'(PERIOD_RESET);
   logic [31:0] trk_iterations   = '0;
   logic [31:0] trk_overruns     = '0;
   logic [31:0] trk_worst_late   = '0;

   fdt_req_type pending_reqs[$];
   fdt_rsp_type expected_rsps[$];

   int  req_idle_pct  = 0;
   int  rsp_idle_pct  = 0;
   bit  req_taken     = 1'b0;
   int  queued_reqs   = 0;
   int  accepted_reqs = 0;
   int  checked_rsps  = 0;
   int  fired_seen    = 0;
   int  overran_seen  = 0;
   int  settings_used = 0;
   int  error_count   = 0;
   int  stall_cycles  = 0;

   fixed_rate_deadline_tracker u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   // Counter width clamped to what the block supports, as a mask
   function automatic logic [31:0] width_mask();
      int width;
      width = cfg_bits;
      if (width < MIN_BITS) width = MIN_BITS;
      if (width > MAX_BITS) width = MAX_BITS;
      return 32'((64'd1 << width) - 64'd1);
   endfunction

   // Period with zero lifted to one and saturated at half the counter range
   function automatic logic [31:0] release_period(input logic [31:0] mask);
      logic [31:0] p;
      p = {1'b0, cfg_period};
      if (p == 32'd0) p = 32'd1;
      if (p > (mask >> 1)) p = mask >> 1;
      return p;
   endfunction

   // Advance the tracker by one request and return the response it owes
   function automatic fdt_rsp_type advance_tracker(input fdt_req_type r);
      logic [31:0] mask;
      logic [31:0] period;
      logic [31:0] now;
      logic [31:0] late;
      fdt_rsp_type rsp;
      mask   = width_mask();
      period = release_period(mask);
      now    = r.now_us & mask;
      rsp.fired   = 1'b0;
      rsp.overran = 1'b0;
      if (r.req_type == REQ_RESET_STATS) begin
         // clear the statistics only; arming and deadline survive
         trk_iterations = '0;
         trk_overruns   = '0;
         trk_worst_late = '0;
      end else if (!trk_armed) begin
         // first poll arms and always releases
         trk_prev_release = now;
         trk_deadline     = (now + period) & mask;
         trk_last_dt      = period;
         trk_armed        = 1'b1;
         trk_iterations   = 32'd1;
         rsp.fired        = 1'b1;
      end else begin
         late = (now - trk_deadline) & mask;
         // lateness in the upper half of the range means the deadline is ahead
         if (late <= (mask >> 1)) begin
            rsp.fired        = 1'b1;
            trk_last_dt      = (now - trk_prev_release) & mask;
            trk_prev_release = now;
            if (late > trk_worst_late) trk_worst_late = late;
            if (late >= period) begin
               // a full period behind: count it and rebase from now
               rsp.overran  = 1'b1;
               trk_overruns = trk_overruns + 32'd1;
               trk_deadline = (now + period) & mask;
            end else begin
               trk_deadline = (trk_deadline + period) & mask;
            end
            trk_iterations = trk_iterations + 32'd1;
         end
      end
      rsp.dt_us           = trk_last_dt;
      rsp.iteration_count = trk_iterations;
      rsp.overrun_count   = trk_overruns;
      rsp.peak_late       = trk_worst_late;
      return rsp;
   endfunction

   // Driver: present requests from the pending queue and roll the receiver's
   // readiness, both on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // hold the current request until it has been taken
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               req_payload <= pending_reqs.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Monitor: predict on each accepted request, check each accepted response
   // against the oldest prediction, and watch for a hung pipeline.
   always @(posedge clock) begin
      fdt_rsp_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            expected_rsps.push_back(advance_tracker(req_payload));
            accepted_reqs++;
         end
         if (rsp_valid && rsp_ready) begin
            checked_rsps++;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.fired === 1'b1) fired_seen++;
               if (rsp_payload.overran === 1'b1) overran_seen++;
               if (rsp_payload.fired !== want.fired) begin
                  $error("fired: expected %0d, got %0d", want.fired, rsp_payload.fired);
                  error_count++;
               end
               if (rsp_payload.overran !== want.overran) begin
                  $error("overran: expected %0d, got %0d", want.overran,
                         rsp_payload.overran);
                  error_count++;
               end
               if (rsp_payload.dt_us !== want.dt_us) begin
                  $error("dt_us: expected %h, got %h", want.dt_us, rsp_payload.dt_us);
                  error_count++;
               end
               if (rsp_payload.iteration_count !== want.iteration_count) begin
                  $error("iteration_count: expected %h, got %h", want.iteration_count,
                         rsp_payload.iteration_count);
                  error_count++;
               end
               if (rsp_payload.overrun_count !== want.overrun_count) begin
                  $error("overrun_count: expected %h, got %h", want.overrun_count,
                         rsp_payload.overrun_count);
                  error_count++;
               end
               if (rsp_payload.peak_late !== want.peak_late) begin
                  $error("peak_late: expected %h, got %h", want.peak_late,
                         rsp_payload.peak_late);
                  error_count++;
               end
            end
         end
         // reset the stall count on any handshake, otherwise advance it
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Add one request to the pending queue (call after a rising edge only)
   task automatic queue_req(input logic kind, input logic [31:0] now);
      fdt_req_type r;
      r.req_type = kind;
      r.now_us   = now;
      pending_reqs.push_back(r);
      queued_reqs++;
   endtask

   // Hold the sender until every queued request has been answered
   task automatic wait_for_drain();
      @(negedge clock);
      while (checked_rsps < queued_reqs) @(negedge clock);
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   // Write both registers back to back; the block is idle here
   task automatic program_tracker(input logic [30:0] period_word,
                                  input logic [30:0] bits_word);
      csr_we    <= 1'b1;
      csr_index <= CSR_PERIOD;
      csr_wdata <= period_word;
      @(negedge clock);
      csr_index <= CSR_COUNTER_BITS;
      csr_wdata <= bits_word;
      @(negedge clock);
      csr_we     <= 1'b0;
      cfg_period = period_word;
      cfg_bits   = bits_word[BITS_WIDTH-1:0];
      settings_used++;
   endtask

   initial begin
      logic [31:0] mask;
      logic [31:0] period;
      logic [31:0] poll_time;
      logic [63:0] step;
      logic [30:0] noise;
      int          roll;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      @(posedge clock);
      req_idle_pct = 38;
      rsp_idle_pct = 72;
      // Reset settings: arm, poll just ahead of and on the deadline, late by
      // less than a period and by exactly one, then straddle half the range.
      queue_req(REQ_POLL, 32'd500);
      queue_req(REQ_POLL, 32'd1499);
      queue_req(REQ_POLL, 32'd1500);
      queue_req(REQ_POLL, 32'd2999);
      queue_req(REQ_POLL, 32'd4500);
      queue_req(REQ_RESET_STATS, 32'hFFFF_FFFF);
      queue_req(REQ_POLL, 32'h8000_157C);
      queue_req(REQ_POLL, 32'h8000_157B);
      queue_req(REQ_POLL, 32'h8000_157B);
      queue_req(REQ_POLL, 32'hFFFF_FFFF);
      queue_req(REQ_RESET_STATS, 32'd0);
      wait_for_drain();

      // Zero period and a width below the minimum: period one, 16-bit counter
      program_tracker(31'd0, 31'h7FFF_FFC0);
      @(posedge clock);
      queue_req(REQ_POLL, 32'hFFFF_0005);
      queue_req(REQ_POLL, 32'hABCD_0400);
      queue_req(REQ_POLL, 32'h0000_0401);
      queue_req(REQ_POLL, 32'h5555_FFFF);
      queue_req(REQ_POLL, 32'h5555_FFFF);
      wait_for_drain();

      // Largest period and a width above the maximum: saturate to half range
      program_tracker(31'h7FFF_FFFF, 31'd63);
      @(posedge clock);
      queue_req(REQ_POLL, 32'd0);
      queue_req(REQ_POLL, 32'h7FFF_FFFF);
      queue_req(REQ_POLL, 32'hFFFF_FFFE);
      queue_req(REQ_RESET_STATS, 32'h1234_5678);
      queue_req(REQ_POLL, 32'h7FFF_FFFD);

      // Random segments: time mostly moves forward in period-sized steps,
      // with overruns, far jumps, stats resets and junk above the counter
      // width mixed in. Two segments per idling pattern.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_for_drain();
         noise = 31'($urandom) & ~31'h3F;
         case (seg)
            0: program_tracker(31'($urandom_range(200, 1)), noise | 31'd32);
            1: program_tracker(31'd1, noise | 31'd16);
            2: program_tracker(31'($urandom_range(5000, 1)), noise | 31'd20);
            3: program_tracker(31'h7FFF_FFFF, noise | 31'd40);
            4: program_tracker(31'($urandom_range(70000, 1)),
                               noise | 31'($urandom_range(32, 16)));
            default: program_tracker(31'($urandom_range(50000, 1)), noise | 31'd17);
         endcase
         @(posedge clock);
         if (seg < 2) begin
            req_idle_pct = 38;
            rsp_idle_pct = 72;
         end else if (seg < 4) begin
            req_idle_pct = 72;
            rsp_idle_pct = 38;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         mask      = width_mask();
         period    = release_period(mask);
         poll_time = $urandom & mask;
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
               queue_req(REQ_RESET_STATS, $urandom);
            end else begin
               if (roll < 45) begin
                  step = 64'($urandom_range(period / 2));
               end else if (roll < 75) begin
                  step = 64'(period - period / 4) + 64'($urandom_range(period / 2));
               end else if (roll < 88) begin
                  step = 64'(period) + 64'($urandom_range(period)) * 64'd2;
               end else if (roll < 95) begin
                  step = 64'($urandom & (mask >> 1));
               end else begin
                  step = 64'($urandom);
               end
               poll_time = 32'(64'(poll_time) + step) & mask;
               // drop random junk into the bits above the counter width
               if ($urandom_range(3) == 0) begin
                  queue_req(REQ_POLL, poll_time | ($urandom & ~mask));
               end else begin
                  queue_req(REQ_POLL, poll_time);
               end
            end
         end
      end

      wait_for_drain();
      $display("Run covered %0d requests and %0d responses over %0d register settings,",
               accepted_reqs, checked_rsps, settings_used);
      $display("with %0d releases and %0d overruns; %0d mismatches.",
               fired_seen, overran_seen, error_count);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
